// File: hw/rtl/nfca_pkg.sv
// Shared types, codes and constants of the next-fit cluster allocator.
package nfca_pkg;

	localparam int unsigned CLUSTER_TOTAL_DEFAULT = 1024;
	localparam int unsigned CMD_QUEUE_DEPTH = 2;

	localparam int unsigned OP_W = 2;
	localparam int unsigned CLUSTER_W = 10;
	localparam int unsigned CFG_W = 10;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [CLUSTER_W-1:0] cluster;
	} in_item_t;

	typedef struct packed {
		logic [CLUSTER_W-1:0] cluster_index;
		logic ok;
	} out_item_t;

	// Work classes that the front hands to the back.
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE = 2'd1,
		CMD_FORMAT = 2'd2,
		CMD_REJECT = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [CLUSTER_W-1:0] addr;
	} cmd_t;

endpackage

// File: hw/rtl/nfca_front.sv
// Front end: accepts request beats and classifies them into commands.
module nfca_front #(
	parameter int unsigned CLUSTER_TOTAL = nfca_pkg::CLUSTER_TOTAL_DEFAULT
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  nfca_pkg::in_item_t            in_data,
	input  logic [nfca_pkg::CFG_W-1:0]    first_eff,
	input  logic                          queue_full,
	input  logic                          init_busy,
	output logic                          push,
	output nfca_pkg::cmd_t                push_cmd
);

	logic free_in_range;

	// A beat is taken only while the queue has room and the map is not being cleared after reset.
	assign in_stall = queue_full || init_busy;
	assign push = in_valid && !in_stall;

	assign free_in_range = (in_data.cluster >= first_eff)
		&& (32'(in_data.cluster) < CLUSTER_TOTAL);

	always_comb begin
		push_cmd.addr = in_data.cluster;
		case (in_data.op)
			nfca_pkg::OP_ALLOC: begin
				push_cmd.kind = nfca_pkg::CMD_ALLOC;
			end
			nfca_pkg::OP_FREE: begin
				push_cmd.kind = free_in_range ? nfca_pkg::CMD_FREE : nfca_pkg::CMD_REJECT;
			end
			nfca_pkg::OP_FORMAT: begin
				push_cmd.kind = nfca_pkg::CMD_FORMAT;
			end
			default: begin
				push_cmd.kind = nfca_pkg::CMD_REJECT;
			end
		endcase
	end

endmodule

// File: hw/rtl/nfca_queue.sv
// Short command queue between the front end and the map engine.
module nfca_queue #(
	parameter int unsigned DEPTH = nfca_pkg::CMD_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nfca_pkg::cmd_t push_cmd,
	input  logic           pop,
	output nfca_pkg::cmd_t pop_cmd,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nfca_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/nfca_back.sv
// Map engine: holds the used map and the search position and runs each command.
module nfca_back #(
	parameter int unsigned CLUSTER_TOTAL = nfca_pkg::CLUSTER_TOTAL_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [nfca_pkg::CFG_W-1:0] first_eff,
	input  logic                       cmd_valid,
	input  nfca_pkg::cmd_t             cmd,
	output logic                       pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  logic                       out_stall,
	output nfca_pkg::out_item_t        out_data
);

	localparam int unsigned AW = $clog2(CLUSTER_TOTAL);
	localparam int unsigned PW = (AW > nfca_pkg::CFG_W) ? AW : nfca_pkg::CFG_W;
	localparam int unsigned CW = PW + 1;
	localparam logic [CW-1:0] N_C = CW'(CLUSTER_TOTAL);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t state_q;
	logic [CW-1:0] clr_q;
	logic report_q;
	logic [PW-1:0] next_q;
	logic [CW-1:0] scan_q;
	logic from_start_q;
	logic chk_valid_s1;
	logic [CW-1:0] chk_addr_s1;
	logic rd_data_s1;
	logic out_valid_q;
	nfca_pkg::out_item_t out_data_q;

	logic used_mem [CLUSTER_TOTAL];

	logic [CW-1:0] first_ext;
	logic [CW-1:0] next_ext;
	logic [CW-1:0] start_c;
	logic [CW-1:0] free_ext;
	logic ready_take;
	logic hit;
	logic scan_live;
	logic clr_last;
	logic produce;
	nfca_pkg::out_item_t res;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic wr_bit;
	logic rd_en;

	assign first_ext = CW'(first_eff);
	assign next_ext = CW'(next_q);
	assign start_c = (next_ext < first_ext) ? first_ext : next_ext;
	assign free_ext = CW'(cmd.addr);
	assign ready_take = !out_valid_q || !out_stall;
	assign hit = chk_valid_s1 && !rd_data_s1;
	assign scan_live = (scan_q < N_C);
	assign clr_last = (clr_q == N_C - 1'b1);
	assign init_busy = (state_q == ST_CLEAR) && !report_q;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		pop = 1'b0;
		produce = 1'b0;
		res = '0;
		wr_en = 1'b0;
		wr_addr = clr_q[AW-1:0];
		wr_bit = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (clr_last && report_q) begin
					produce = 1'b1;
					res.ok = 1'b1;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && ready_take) begin
					pop = 1'b1;
					case (cmd.kind)
						nfca_pkg::CMD_FREE: begin
							wr_en = 1'b1;
							wr_addr = free_ext[AW-1:0];
							produce = 1'b1;
							res.ok = 1'b1;
						end
						nfca_pkg::CMD_REJECT: begin
							produce = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr_en = 1'b1;
					wr_addr = chk_addr_s1[AW-1:0];
					wr_bit = 1'b1;
					produce = 1'b1;
					res.cluster_index = chk_addr_s1[nfca_pkg::CLUSTER_W-1:0];
					res.ok = 1'b1;
				end else if (scan_live) begin
					rd_en = 1'b1;
				end else if (from_start_q) begin
					produce = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_addr] <= wr_bit;
		end
		if (rd_en) begin
			rd_data_s1 <= used_mem[scan_q[AW-1:0]];
			chk_addr_s1 <= scan_q;
		end
		if (produce) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			report_q <= 1'b0;
			next_q <= PW'(1);
			scan_q <= '0;
			from_start_q <= 1'b0;
			chk_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_last) begin
						clr_q <= '0;
						report_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							nfca_pkg::CMD_ALLOC: begin
								scan_q <= start_c;
								from_start_q <= (start_c == first_ext);
								chk_valid_s1 <= 1'b0;
								state_q <= ST_SCAN;
							end
							nfca_pkg::CMD_FORMAT: begin
								report_q <= 1'b1;
								clr_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						next_q <= chk_addr_s1[PW-1:0];
						chk_valid_s1 <= 1'b0;
						state_q <= ST_IDLE;
					end else if (scan_live) begin
						chk_valid_s1 <= 1'b1;
						scan_q <= scan_q + 1'b1;
					end else begin
						chk_valid_s1 <= 1'b0;
						if (from_start_q) begin
							state_q <= ST_IDLE;
						end else begin
							next_q <= PW'(first_eff);
							scan_q <= first_ext;
							from_start_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The result slot is drained before a scan starts, so a hit always has room.
	a_scan_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !out_valid_q)
		else $error("result slot busy during scan");

	a_hit_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hit) |=> out_valid_q && out_data_q.ok && (state_q == ST_IDLE))
		else $error("allocation hit not reported");

	a_chk_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		chk_valid_s1 |-> (chk_addr_s1 < N_C))
		else $error("scan checked an address outside the map");

	a_format_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_last && report_q) |=> out_valid_q && out_data_q.ok
			&& (out_data_q.cluster_index == '0))
		else $error("format completion not reported");

endmodule

// File: hw/rtl/next_fit_cluster_allocator_core.sv
// Top level: next-fit cluster allocator with config register, front end, queue and map engine.
// A free or rejected request's result is registered after the queue, and these sustain one beat
// per cycle while the result is not stalled. An allocate's scan reads one map entry per cycle and
// wraps at most once back to the first allocatable position. Format sweeps the map and then
// reports. After reset the map is cleared, during which requests are stalled.
module next_fit_cluster_allocator_core #(
	parameter int unsigned CLUSTER_TOTAL = nfca_pkg::CLUSTER_TOTAL_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  nfca_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output nfca_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [nfca_pkg::CFG_W-1:0] cfg_data
);

	// The first allocatable position. Writes land at once; a zero is read as one so
	// that cluster zero is never handed out and zero can always signal failure.
	logic [nfca_pkg::CFG_W-1:0] first_q;
	logic [nfca_pkg::CFG_W-1:0] first_eff;

	logic push;
	nfca_pkg::cmd_t push_cmd;
	logic pop;
	nfca_pkg::cmd_t pop_cmd;
	logic queue_full;
	logic queue_empty;
	logic init_busy;

	// The register port never pushes back.
	assign cfg_ready = 1'b1;
	assign first_eff = (first_q == '0) ? nfca_pkg::CFG_W'(1) : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= nfca_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			first_q <= cfg_data;
		end
	end

	// The front end turns each request beat into a command: frees outside the
	// allocatable range and the unused opcode become rejects, answered without
	// touching the map.
	nfca_front #(
		.CLUSTER_TOTAL(CLUSTER_TOTAL)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.first_eff  (first_eff),
		.queue_full (queue_full),
		.init_busy  (init_busy),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// The queue lets the front keep taking beats while the engine is scanning
	// or waiting on a stalled result.
	nfca_queue #(
		.DEPTH(nfca_pkg::CMD_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	// The engine owns the used map and the next-fit position. It takes a new
	// command only when its result register is free or draining, and holds the
	// finished result there until the downstream side takes the beat.
	nfca_back #(
		.CLUSTER_TOTAL(CLUSTER_TOTAL)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.first_eff (first_eff),
		.cmd_valid (!queue_empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
